// ===== src/hrkd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, keycode constants and key decode functions for the HID report decoder.
// No dependencies; imported by every module of the block.
package hrkd_pkg;

  localparam int unsigned KEY_SLOTS = 6;
  localparam int unsigned MAX_SLOTS = 6;

  localparam logic [7:0] SHIFT_MASK = 8'h22;

  localparam logic [7:0] KC_A     = 8'h04;
  localparam logic [7:0] KC_Z     = 8'h1d;
  localparam logic [7:0] KC_1     = 8'h1e;
  localparam logic [7:0] KC_0     = 8'h27;
  localparam logic [7:0] KC_ENTER = 8'h28;
  localparam logic [7:0] KC_ESC   = 8'h29;
  localparam logic [7:0] KC_BKSP  = 8'h2a;
  localparam logic [7:0] KC_SPACE = 8'h2c;
  localparam logic [7:0] KC_PUNC0 = 8'h2d;
  localparam logic [7:0] KC_PUNC1 = 8'h38;
  localparam logic [7:0] KC_RIGHT = 8'h4f;
  localparam logic [7:0] KC_LEFT  = 8'h50;

  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_SPACE   = 7'h20;

  typedef enum logic [2:0] {
    EVT_CHAR  = 3'd0,
    EVT_LEFT  = 3'd1,
    EVT_RIGHT = 3'd2,
    EVT_BKSP  = 3'd3,
    EVT_ENTER = 3'd4
  } evt_kind_e;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;
  } key_report_t;

  typedef struct packed {
    evt_kind_e  event_kind;
    logic       escape_flag;
    logic [6:0] ascii_char;
    logic       last_event;
  } key_evt_t;

  typedef struct packed {
    logic     hit;
    key_evt_t evt;
  } lane_res_t;

  function automatic logic [6:0] digit_char(logic [3:0] idx, logic shift);
    logic [6:0] c;
    case (idx)
      4'd0:    c = shift ? 7'h21 : 7'h31;
      4'd1:    c = shift ? 7'h40 : 7'h32;
      4'd2:    c = shift ? 7'h23 : 7'h33;
      4'd3:    c = shift ? 7'h24 : 7'h34;
      4'd4:    c = shift ? 7'h25 : 7'h35;
      4'd5:    c = shift ? 7'h5e : 7'h36;
      4'd6:    c = shift ? 7'h26 : 7'h37;
      4'd7:    c = shift ? 7'h2a : 7'h38;
      4'd8:    c = shift ? 7'h28 : 7'h39;
      4'd9:    c = shift ? 7'h29 : 7'h30;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // zero marks a keycode with no mapping
  function automatic logic [6:0] punct_char(logic [3:0] idx, logic shift);
    logic [6:0] c;
    case (idx)
      4'd0:    c = shift ? 7'h5f : 7'h2d;
      4'd1:    c = shift ? 7'h2b : 7'h3d;
      4'd2:    c = shift ? 7'h7b : 7'h5b;
      4'd3:    c = shift ? 7'h7d : 7'h5d;
      4'd4:    c = shift ? 7'h7c : 7'h5c;
      4'd6:    c = shift ? 7'h3a : 7'h3b;
      4'd7:    c = shift ? 7'h22 : 7'h27;
      4'd8:    c = shift ? 7'h7e : 7'h60;
      4'd9:    c = shift ? 7'h3c : 7'h2c;
      4'd10:   c = shift ? 7'h3e : 7'h2e;
      4'd11:   c = shift ? 7'h3f : 7'h2f;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic lane_res_t decode_key(logic [7:0] kc, logic shift);
    lane_res_t r;
    r = '0;
    r.hit = 1'b1;
    r.evt.event_kind = EVT_CHAR;
    case (kc) inside
      KC_LEFT:  r.evt.event_kind = EVT_LEFT;
      KC_RIGHT: r.evt.event_kind = EVT_RIGHT;
      KC_BKSP:  r.evt.event_kind = EVT_BKSP;
      KC_ENTER: r.evt.event_kind = EVT_ENTER;
      [KC_A:KC_Z]: begin
        r.evt.ascii_char = (shift ? ASCII_UPPER_A : ASCII_LOWER_A) + (kc[6:0] - KC_A[6:0]);
      end
      [KC_1:KC_0]: r.evt.ascii_char = digit_char(4'(kc - KC_1), shift);
      KC_SPACE:    r.evt.ascii_char = ASCII_SPACE;
      [KC_PUNC0:KC_PUNC1]: begin
        r.evt.ascii_char = punct_char(4'(kc - KC_PUNC0), shift);
        r.hit = (r.evt.ascii_char != 7'h00);
      end
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/hrkd_lane.sv =====
`timescale 1ns / 1ps
// One decode lane: flags a new press in its slot and decodes it into an event.
// Depends on hrkd_pkg.
module hrkd_lane #(
  parameter int unsigned KeySlots = hrkd_pkg::KEY_SLOTS
) (
  input  logic [7:0]                key_i,
  input  logic [KeySlots-1:0][7:0] prev_i,
  input  logic                      shift_i,
  output hrkd_pkg::lane_res_t       res_o
);
  import hrkd_pkg::*;

  logic      seen;
  lane_res_t dec;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < KeySlots; j++) begin
      if (prev_i[j] == key_i) seen = 1'b1;
    end
  end

  assign dec = decode_key(key_i, shift_i);

  always_comb begin
    res_o     = dec;
    res_o.hit = dec.hit && (key_i != 8'h00) && !seen;
  end

endmodule

// ===== src/hrkd_merge.sv =====
`timescale 1ns / 1ps
// Merge stage: holds the lane events of one report and sends them out one beat at a time.
// Depends on hrkd_pkg.
module hrkd_merge #(
  parameter int unsigned KeySlots = hrkd_pkg::KEY_SLOTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [KeySlots-1:0]                 load_mask_i,
  input  hrkd_pkg::key_evt_t [KeySlots-1:0]   load_evt_i,
  output logic                                load_ready_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output hrkd_pkg::key_evt_t                  out_data_o
);
  import hrkd_pkg::*;

  logic [KeySlots-1:0] pend_q, pend_d;
  logic [KeySlots-1:0] low;
  logic [KeySlots-1:0] rest;
  key_evt_t [KeySlots-1:0] evt_q;
  key_evt_t sel_evt;
  key_evt_t out_q;
  logic out_valid_q;
  logic advance;
  logic single;

  assign advance = !out_valid_q || out_ready_i;
  assign low     = pend_q & (~pend_q + 1'b1);
  assign rest    = pend_q & ~low;
  assign single  = (rest == '0);

  assign load_ready_o = (pend_q == '0) || (advance && single);

  always_comb begin
    sel_evt = '0;
    for (int i = 0; i < KeySlots; i++) begin
      if (low[i]) sel_evt = sel_evt | evt_q[i];
    end
    sel_evt.last_event = (rest == '0);
  end

  always_comb begin
    if (load_i) begin
      pend_d = load_mask_i;
    end else if (advance) begin
      pend_d = rest;
    end else begin
      pend_d = pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (advance) begin
        out_valid_q <= (pend_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      evt_q <= load_evt_i;
    end
    if (advance && (pend_q != '0)) begin
      out_q <= sel_evt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_multi_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rest != '0) |-> !load_ready_o)
    else $error("input taken while several events still pending");

  a_not_last_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.last_event) |-> (pend_q != '0))
    else $error("non-final beat with nothing pending");

  a_escape_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.escape_flag) |-> out_q.last_event)
    else $error("escape beat not marked last");

  a_pend_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pend_q != '0) && !out_valid_q) |=> out_valid_q)
    else $error("pending event not moved to output");

endmodule

// ===== src/hid_report_key_event_decoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the HID boot keyboard report decoder: lanes, previous-report store, merge.
// Depends on hrkd_pkg, hrkd_lane and hrkd_merge.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one boot keyboard report per
//   beat: a modifier byte and six keycode slots. Output channel
//   (out_valid_o/out_ready_i/out_data_o) gives zero to KeySlots event beats per report,
//   in slot order, with last_event set on the final one. A report holding the escape
//   key gives exactly one escape beat and leaves the stored report unchanged.
//   The first event of an accepted report waits in the merge stage's pending mask, then
//   moves to the output register once it is free or drains. The KeySlots decode lanes
//   check all slots against the stored report combinationally.
//   Throughput: one event beat per cycle while the receiver does not stall; the next
//   report is taken in the cycle the last event of the one before moves to the output
//   register (one report per cycle when each gives at most one event and no stall).
//   Reset clears the stored report to all zeros and drops any pending events.
//   When the receiver stalls, the output beat holds; input is refused while the merge
//   stage holds more than one event, or one event that cannot move to the output.
module hid_report_key_event_decoder_unit #(
  parameter int unsigned KeySlots = hrkd_pkg::KEY_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hrkd_pkg::key_report_t in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hrkd_pkg::key_evt_t    out_data_o
);
  import hrkd_pkg::*;

  logic [MAX_SLOTS-1:0][7:0] slots;
  logic [KeySlots-1:0][7:0]  prev_q;
  logic [KeySlots-1:0][7:0]  cur;
  lane_res_t [KeySlots-1:0]  lane_res;
  logic [KeySlots-1:0]       load_mask;
  key_evt_t [KeySlots-1:0]   load_evt;
  logic                      shift;
  logic                      escape;
  logic                      load;

  assign slots = {in_data_i.key_slot5, in_data_i.key_slot4, in_data_i.key_slot3,
                  in_data_i.key_slot2, in_data_i.key_slot1, in_data_i.key_slot0};
  assign shift = ((in_data_i.modifiers & SHIFT_MASK) != 8'h00);
  assign load  = in_valid_i && in_ready_o;

  always_comb begin
    escape = 1'b0;
    for (int i = 0; i < KeySlots; i++) begin
      cur[i] = slots[i];
      if (slots[i] == KC_ESC) escape = 1'b1;
    end
  end

  for (genvar g = 0; g < KeySlots; g++) begin : g_lane
    hrkd_lane #(
      .KeySlots(KeySlots)
    ) u_lane (
      .key_i  (cur[g]),
      .prev_i (prev_q),
      .shift_i(shift),
      .res_o  (lane_res[g])
    );
  end

  always_comb begin
    for (int i = 0; i < KeySlots; i++) begin
      load_mask[i] = lane_res[i].hit;
      load_evt[i]  = lane_res[i].evt;
    end
    if (escape) begin
      load_mask                = '0;
      load_mask[0]             = 1'b1;
      load_evt[0]              = '0;
      load_evt[0].event_kind   = EVT_ENTER;
      load_evt[0].escape_flag  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (load && !escape) begin
      prev_q <= cur;
    end
  end

  hrkd_merge #(
    .KeySlots(KeySlots)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .load_mask_i (load_mask),
    .load_evt_i  (load_evt),
    .load_ready_o(in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
